>>> src/efd_pkg.sv
// shared types, constants and helpers for the escaped frame deframer
package efd_pkg;

  localparam int META_BYTES  = 7;
  localparam int COUNT_WIDTH = 16;
  localparam int MAX_TYPES   = 5;
  localparam int LEN_W       = 5;
  localparam int TABLE_W     = MAX_TYPES * LEN_W;
  localparam int CNT_W       = 6;
  localparam int GOOD_W      = 16;
  localparam int CFG_W       = TABLE_W;

  localparam logic [7:0] MARK_BYTE = 8'h1A;

  localparam logic [7:0]         TYPE_BASE_RST = 8'd49;
  localparam logic [2:0]         TYPE_COUNT_RST = 3'd5;
  localparam logic [TABLE_W-1:0] LEN_TABLE_RST = TABLE_W'(15153378);

  typedef enum logic [1:0] {
    CFG_TYPE_BASE  = 2'd0,
    CFG_TYPE_COUNT = 2'd1,
    CFG_LEN_TABLE  = 2'd2
  } efd_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_HUNT     = 3'd0,
    ST_HUNT_GOT = 3'd1,
    ST_MARKER   = 3'd2,
    ST_TYPE     = 3'd3,
    ST_BODY     = 3'd4,
    ST_ESCAPE   = 3'd5
  } efd_state_t;

  typedef enum logic [1:0] {
    EV_IDLE = 2'd0,
    EV_META = 2'd1,
    EV_DATA = 2'd2,
    EV_LOST = 2'd3
  } efd_event_t;

  typedef struct packed {
    efd_state_t             state;
    logic [2:0]             frame_type;
    logic [CNT_W-1:0]       byte_count;
    logic                   sync;
    logic [COUNT_WIDTH-1:0] good;
  } efd_ctx_t;

  typedef struct packed {
    efd_event_t       ev;
    logic [7:0]       payload;
    logic [CNT_W-1:0] pos;
    logic             frame_end;
  } efd_res_t;

  // data length of a frame type, type index taken modulo MAX_TYPES
  function automatic logic [LEN_W-1:0] len_of(input logic [TABLE_W-1:0] tbl,
                                               input logic [2:0] ft);
    logic [LEN_W-1:0] l;
    case (ft)
      3'd0: l = tbl[0*LEN_W +: LEN_W];
      3'd1: l = tbl[1*LEN_W +: LEN_W];
      3'd2: l = tbl[2*LEN_W +: LEN_W];
      3'd3: l = tbl[3*LEN_W +: LEN_W];
      3'd4: l = tbl[4*LEN_W +: LEN_W];
      3'd5: l = tbl[0*LEN_W +: LEN_W];
      3'd6: l = tbl[1*LEN_W +: LEN_W];
      default: l = tbl[2*LEN_W +: LEN_W];
    endcase
    return l;
  endfunction

endpackage

>>> src/efd_parse.sv
// next-state and result logic of the deframer for one received byte
module efd_parse (
  input  efd_pkg::efd_ctx_t             ctx,
  input  logic                          command,
  input  logic [7:0]                    rx_byte,
  input  logic [7:0]                    type_base,
  input  logic [2:0]                    type_count,
  input  logic [efd_pkg::TABLE_W-1:0]   length_table,
  output efd_pkg::efd_ctx_t             ctx_next,
  output efd_pkg::efd_res_t             res
);
  import efd_pkg::*;

  logic [7:0]       type_off;
  logic [2:0]       type_lim;
  logic             type_ok;
  logic             is_mark;
  logic [LEN_W-1:0] body_len;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W:0]   total;
  logic             body_done;
  logic             take;
  logic             lost;

  assign is_mark   = (rx_byte == MARK_BYTE);
  assign type_off  = rx_byte - type_base;
  assign type_lim  = (type_count > 3'(MAX_TYPES)) ? 3'(MAX_TYPES) : type_count;
  assign type_ok   = (type_off < {5'd0, type_lim});
  assign body_len  = len_of(length_table, ctx.frame_type);
  assign count_inc = ctx.byte_count + 1'b1;
  assign total     = (CNT_W+1)'(META_BYTES) + (CNT_W+1)'(body_len);
  assign body_done = ({1'b0, count_inc} >= total);

  always_comb begin
    ctx_next = ctx;
    res      = '0;
    res.ev   = EV_IDLE;
    take     = 1'b0;
    lost     = 1'b0;

    if (command) begin
      ctx_next.state      = ST_MARKER;
      ctx_next.sync       = 1'b0;
      ctx_next.good       = '0;
      ctx_next.byte_count = '0;
    end else begin
      case (ctx.state)
        ST_MARKER: begin
          if (is_mark) ctx_next.state = ST_TYPE;
          else lost = 1'b1;
        end
        ST_TYPE: begin
          if (type_ok) begin
            ctx_next.frame_type = type_off[2:0];
            ctx_next.byte_count = '0;
            ctx_next.state      = ST_BODY;
          end else begin
            lost = 1'b1;
          end
        end
        ST_BODY: begin
          if (is_mark) ctx_next.state = ST_ESCAPE;
          else take = 1'b1;
        end
        ST_ESCAPE: begin
          if (is_mark) take = 1'b1;
          else lost = 1'b1;
        end
        ST_HUNT_GOT: begin
          ctx_next.state = is_mark ? ST_TYPE : ST_HUNT_GOT;
        end
        default: begin
          ctx_next.state = is_mark ? ST_HUNT : ST_HUNT_GOT;
        end
      endcase

      // resync hunt restarts on the offending byte
      if (lost) begin
        ctx_next.sync       = 1'b0;
        ctx_next.good       = '0;
        ctx_next.byte_count = '0;
        ctx_next.state      = is_mark ? ST_HUNT : ST_HUNT_GOT;
        res.ev              = EV_LOST;
      end

      if (take) begin
        res.ev      = (ctx.byte_count < CNT_W'(META_BYTES)) ? EV_META : EV_DATA;
        res.payload = rx_byte;
        res.pos     = ctx.byte_count;
        if (body_done) begin
          res.frame_end       = 1'b1;
          ctx_next.sync       = 1'b1;
          ctx_next.byte_count = '0;
          ctx_next.state      = ST_MARKER;
          if (ctx.good != '1) ctx_next.good = ctx.good + 1'b1;
        end else begin
          ctx_next.byte_count = count_inc;
          ctx_next.state      = ST_BODY;
        end
      end
    end
  end

endmodule

>>> src/escaped_frame_deframer_unit.sv
// top level of the escaped frame deframer: input register, parser state, result register
// path: an input byte passes the input register and the combinational parser into the result register
// throughput: one byte per cycle while in_stall is low, the parser step being combinational on the input register
// a full result register with out_stall high holds a full input register and raises in_stall
// reset: synchronous, clears both valid flags and the parser state, config to defaults
module escaped_frame_deframer_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                command,
  input  logic [7:0]                          rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          event_res,
  output logic [7:0]                          payload_byte,
  output logic [2:0]                          type_index,
  output logic [efd_pkg::CNT_W-1:0]           byte_position,
  output logic                                frame_end,
  output logic                                in_sync,
  output logic [efd_pkg::GOOD_W-1:0]          good_frames,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [efd_pkg::CFG_W-1:0]           cfg_data
);
  import efd_pkg::*;

  logic [7:0]         type_base;
  logic [2:0]         type_count;
  logic [TABLE_W-1:0] length_table;

  logic               in_q_valid;
  logic               in_q_cmd;
  logic [7:0]         in_q_byte;

  efd_ctx_t           ctx;
  efd_ctx_t           ctx_next;
  efd_res_t           res;
  logic               advance;
  logic               step;
  logic [31:0]        good_ext;

  assign advance  = !out_valid || !out_stall;
  assign step     = in_q_valid && advance;
  assign in_stall = in_q_valid && !advance;
  assign good_ext = 32'(ctx_next.good);

  always_ff @(posedge clk) begin
    if (rst) begin
      type_base    <= TYPE_BASE_RST;
      type_count   <= TYPE_COUNT_RST;
      length_table <= LEN_TABLE_RST;
    end else if (cfg_we) begin
      case (efd_cfg_idx_t'(cfg_index))
        CFG_TYPE_BASE:  type_base    <= cfg_data[7:0];
        CFG_TYPE_COUNT: type_count   <= cfg_data[2:0];
        CFG_LEN_TABLE:  length_table <= cfg_data[TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_cmd  <= command;
      in_q_byte <= rx_byte;
    end
  end

  efd_parse u_parse (
    .ctx          (ctx),
    .command      (in_q_cmd),
    .rx_byte      (in_q_byte),
    .type_base    (type_base),
    .type_count   (type_count),
    .length_table (length_table),
    .ctx_next     (ctx_next),
    .res          (res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state      <= ST_MARKER;
      ctx.frame_type <= '0;
      ctx.byte_count <= '0;
      ctx.sync       <= 1'b0;
      ctx.good       <= '0;
    end else if (step) begin
      ctx <= ctx_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      event_res     <= res.ev;
      payload_byte  <= res.payload;
      type_index    <= ctx_next.frame_type;
      byte_position <= res.pos;
      frame_end     <= res.frame_end;
      in_sync       <= ctx_next.sync;
      good_frames   <= good_ext[GOOD_W-1:0];
    end
  end

endmodule

>>> src/efd_checker.sv
// port-level checks of the escaped frame deframer and their bind
module efd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  event_res,
  input logic [7:0]                  payload_byte,
  input logic [efd_pkg::CNT_W-1:0]   byte_position,
  input logic                        frame_end,
  input logic                        in_sync,
  input logic [efd_pkg::GOOD_W-1:0]  good_frames
);
  import efd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(event_res))
    else $error("stalled result changed");

  // frame end only on a body byte and leaves the block in sync with a count
  a_end_sync: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |->
      in_sync && good_frames != '0 &&
      (event_res == EV_META || event_res == EV_DATA))
    else $error("frame end without sync");

  // sync loss clears sync and the good count
  a_lost_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_LOST |-> !in_sync && good_frames == '0 && !frame_end)
    else $error("sync loss left state");

  // non-payload transfers carry no byte or position
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_IDLE || event_res == EV_LOST) |->
      payload_byte == '0 && byte_position == '0)
    else $error("payload on non-payload transfer");

endmodule

bind escaped_frame_deframer_unit efd_checker u_efd_checker (.*);

>>> tb/sv/tb_top.sv
// self-checking testbench for the escaped frame deframer: directed table and random frames
module tb_top;
  import efd_pkg::*;

  typedef struct packed {
    efd_event_t        ev;
    logic [7:0]        payload;
    logic [2:0]        ftype;
    logic [CNT_W-1:0]  pos;
    logic              fend;
    logic              sync;
    logic [GOOD_W-1:0] good;
  } rx_result_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       typed;
    rx_result_t res;
  } dir_row_t;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam int KIND_GARBAGE    = 7;
  localparam int KIND_BAD_TYPE   = 8;
  localparam int KIND_BAD_ESCAPE = 9;
  localparam int KIND_RESTART    = 10;

  localparam int DIR_ROWS    = 27;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 170;
  localparam int MAX_REPORTS = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = CMD_BYTE;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] event_res;
  logic [7:0] payload_byte;
  logic [2:0] type_index;
  logic [CNT_W-1:0] byte_position;
  logic frame_end;
  logic in_sync;
  logic [GOOD_W-1:0] good_frames;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_TYPE_BASE;
  logic [CFG_W-1:0] cfg_data = '0;

  // mirror of the block's registers and parser
  logic [7:0] base_cfg = TYPE_BASE_RST;
  logic [2:0] count_cfg = TYPE_COUNT_RST;
  logic [TABLE_W-1:0] len_cfg = LEN_TABLE_RST;
  efd_state_t parse_st = ST_MARKER;
  logic [2:0] cur_type = '0;
  logic [CNT_W-1:0] body_cnt = '0;
  logic synced = 1'b0;
  logic [GOOD_W-1:0] good_cnt = '0;

  rx_result_t deframed_q[$];
  int mismatches = 0;
  int unsigned items_sent = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  dir_row_t directed [DIR_ROWS] = '{
    '{CMD_RESTART, 8'h1A, 1'b1, '{EV_IDLE, 8'h00, 3'd0, 6'd0, 1'b0, 1'b0, 16'd0}},
    '{CMD_BYTE, 8'h00, 1'b1, '{EV_LOST, 8'h00, 3'd0, 6'd0, 1'b0, 1'b0, 16'd0}},
    '{CMD_BYTE, 8'h1A, 1'b1, '{EV_IDLE, 8'h00, 3'd0, 6'd0, 1'b0, 1'b0, 16'd0}},
    '{CMD_BYTE, 8'h31, 1'b1, '{EV_IDLE, 8'h00, 3'd0, 6'd0, 1'b0, 1'b0, 16'd0}},
    '{CMD_BYTE, 8'h00, 1'b1, '{EV_META, 8'h00, 3'd0, 6'd0, 1'b0, 1'b0, 16'd0}},
    '{CMD_BYTE, 8'hFF, 1'b1, '{EV_META, 8'hFF, 3'd0, 6'd1, 1'b0, 1'b0, 16'd0}},
    '{CMD_BYTE, 8'h1A, 1'b0, '0},
    '{CMD_BYTE, 8'h1A, 1'b0, '0},
    '{CMD_BYTE, 8'h80, 1'b0, '0},
    '{CMD_BYTE, 8'h7F, 1'b0, '0},
    '{CMD_BYTE, 8'h01, 1'b0, '0},
    '{CMD_BYTE, 8'hFE, 1'b0, '0},
    '{CMD_BYTE, 8'h1A, 1'b0, '0},
    '{CMD_BYTE, 8'h1A, 1'b0, '0},
    '{CMD_BYTE, 8'hAA, 1'b1, '{EV_DATA, 8'hAA, 3'd0, 6'd8, 1'b1, 1'b1, 16'd1}},
    '{CMD_BYTE, 8'h1A, 1'b0, '0},
    '{CMD_BYTE, 8'h36, 1'b1, '{EV_LOST, 8'h00, 3'd0, 6'd0, 1'b0, 1'b0, 16'd0}},
    '{CMD_BYTE, 8'h1A, 1'b0, '0},
    '{CMD_BYTE, 8'h30, 1'b0, '0},
    '{CMD_BYTE, 8'h1A, 1'b0, '0},
    '{CMD_BYTE, 8'h35, 1'b0, '0},
    '{CMD_BYTE, 8'h1A, 1'b0, '0},
    '{CMD_BYTE, 8'h33, 1'b1, '{EV_LOST, 8'h00, 3'd4, 6'd0, 1'b0, 1'b0, 16'd0}},
    '{CMD_BYTE, 8'h1A, 1'b0, '0},
    '{CMD_BYTE, 8'h1A, 1'b0, '0},
    '{CMD_BYTE, 8'h1A, 1'b0, '0},
    '{CMD_RESTART, 8'hC5, 1'b1, '{EV_IDLE, 8'h00, 3'd4, 6'd0, 1'b0, 1'b0, 16'd0}}
  };

  escaped_frame_deframer_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_res(event_res),
    .payload_byte(payload_byte),
    .type_index(type_index),
    .byte_position(byte_position),
    .frame_end(frame_end),
    .in_sync(in_sync),
    .good_frames(good_frames),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic efd_state_t hunt_next(input efd_state_t s, input logic [7:0] b);
    if (b != MARK_BYTE) return ST_HUNT_GOT;
    if (s == ST_HUNT_GOT) return ST_TYPE;
    return ST_HUNT;
  endfunction

  function automatic rx_result_t deframe_byte(input logic c, input logic [7:0] b);
    rx_result_t r;
    logic [7:0] idx;
    int unsigned lim;
    int unsigned total;
    logic lost;
    r = '0;
    lost = 1'b0;
    if (c == CMD_RESTART) begin
      parse_st = ST_MARKER;
      synced = 1'b0;
      good_cnt = '0;
      body_cnt = '0;
    end else begin
      case (parse_st)
        ST_MARKER: begin
          if (b == MARK_BYTE) parse_st = ST_TYPE;
          else lost = 1'b1;
        end
        ST_TYPE: begin
          idx = b - base_cfg;
          lim = (count_cfg > MAX_TYPES) ? MAX_TYPES : count_cfg;
          if (idx < lim) begin
            cur_type = idx[2:0];
            body_cnt = '0;
            parse_st = ST_BODY;
          end else begin
            lost = 1'b1;
          end
        end
        ST_BODY, ST_ESCAPE: begin
          if (parse_st == ST_BODY && b == MARK_BYTE) begin
            parse_st = ST_ESCAPE;
          end else if (parse_st == ST_ESCAPE && b != MARK_BYTE) begin
            lost = 1'b1;
          end else begin
            total = META_BYTES + len_cfg[LEN_W*(cur_type % MAX_TYPES) +: LEN_W];
            r.ev = (body_cnt < META_BYTES) ? EV_META : EV_DATA;
            r.payload = b;
            r.pos = body_cnt;
            if (body_cnt + 1 >= total) begin
              r.fend = 1'b1;
              synced = 1'b1;
              if (good_cnt != '1) good_cnt = good_cnt + 1'b1;
              body_cnt = '0;
              parse_st = ST_MARKER;
            end else begin
              body_cnt = body_cnt + 1'b1;
              parse_st = ST_BODY;
            end
          end
        end
        default: parse_st = hunt_next(parse_st, b);
      endcase
      if (lost) begin
        synced = 1'b0;
        good_cnt = '0;
        body_cnt = '0;
        r.ev = EV_LOST;
        parse_st = hunt_next(ST_HUNT, b);
      end
    end
    r.ftype = cur_type;
    r.sync = synced;
    r.good = good_cnt;
    return r;
  endfunction

  task automatic send_item(input logic c, input logic [7:0] b, input logic typed = 1'b0,
                           input rx_result_t typed_res = '0);
    rx_result_t pred;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    rx_byte <= b;
    // hold the item until the transfer
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = deframe_byte(c, b);
    deframed_q = {deframed_q, (typed ? typed_res : pred)};
    items_sent++;
  endtask

  task automatic send_body(input int unsigned n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = ($urandom_range(0, 4) == 0) ? MARK_BYTE : 8'($urandom_range(0, 255));
      if (b == MARK_BYTE) send_item(CMD_BYTE, b);
      send_item(CMD_BYTE, b);
    end
  endtask

  task automatic send_frame(input bit clean);
    int unsigned lim;
    int unsigned kind;
    int unsigned ft;
    int unsigned len;
    logic [7:0] b;
    lim = (count_cfg > MAX_TYPES) ? MAX_TYPES : count_cfg;
    kind = clean ? 0 : $urandom_range(0, KIND_RESTART);
    ft = (lim == 0) ? 0 : $urandom_range(0, lim - 1);
    len = META_BYTES + len_cfg[LEN_W*ft +: LEN_W];
    if (kind == KIND_RESTART) begin
      send_item(CMD_RESTART, 8'($urandom_range(0, 255)));
    end else if (kind == KIND_GARBAGE) begin
      repeat ($urandom_range(1, 6))
        send_item(CMD_BYTE, ($urandom_range(0, 2) == 0) ? MARK_BYTE : 8'($urandom_range(0, 255)));
    end else begin
      send_item(CMD_BYTE, MARK_BYTE);
      if (kind == KIND_BAD_TYPE || lim == 0) begin
        send_item(CMD_BYTE, base_cfg + 8'($urandom_range(lim, 255)));
      end else begin
        send_item(CMD_BYTE, base_cfg + 8'(ft));
        if (kind == KIND_BAD_ESCAPE) begin
          send_body($urandom_range(0, len - 1));
          b = 8'($urandom_range(0, 255));
          send_item(CMD_BYTE, MARK_BYTE);
          send_item(CMD_BYTE, (b == MARK_BYTE) ? 8'h00 : b);
        end else begin
          send_body(len);
        end
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] b, input logic [2:0] c,
                            input logic [TABLE_W-1:0] t);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TYPE_BASE;
    cfg_data <= CFG_W'(b);
    @(negedge clk);
    cfg_index <= CFG_TYPE_COUNT;
    cfg_data <= CFG_W'(c);
    @(negedge clk);
    cfg_index <= CFG_LEN_TABLE;
    cfg_data <= CFG_W'(t);
    @(negedge clk);
    cfg_we <= 1'b0;
    base_cfg = b;
    count_cfg = c;
    len_cfg = t;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (stall_left == 0 && idle_on && !rst && $urandom_range(0, 15) == 0)
      stall_left = $urandom_range(1, 19);
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin : result_check
    rx_result_t got;
    rx_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{efd_event_t'(event_res), payload_byte, type_index, byte_position,
              frame_end, in_sync, good_frames};
      if (deframed_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        want = deframed_q.pop_front();
        check_field("event_res", want.ev, got.ev);
        check_field("payload_byte", want.payload, got.payload);
        check_field("type_index", want.ftype, got.ftype);
        check_field("byte_position", want.pos, got.pos);
        check_field("frame_end", want.fend, got.fend);
        check_field("in_sync", want.sync, got.sync);
        check_field("good_frames", want.good, got.good);
      end
    end
  end

  initial begin
    int unsigned start;
    logic [7:0] pb;
    logic [2:0] pc;
    logic [TABLE_W-1:0] pt;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i])
      send_item(directed[i].cmd, directed[i].data, directed[i].typed, directed[i].res);
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      pb = 8'($urandom_range(0, 255));
      pc = 3'($urandom_range(1, 5));
      pt = TABLE_W'($urandom);
      case (p)
        0: begin
          pb = 8'h00;
          pc = 3'd1;
          pt = '0;
        end
        1: begin
          pb = 8'hFF;
          pc = 3'd5;
          pt = '1;
        end
        2: begin
          pb = 8'h18;
          pc = 3'd3;
        end
        3: pc = 3'd0;
        4: pc = 3'd7;
        5: pc = 3'd6;
        7: begin
          pb = TYPE_BASE_RST;
          pc = TYPE_COUNT_RST;
          pt = LEN_TABLE_RST;
        end
        default: ;
      endcase
      write_regs(pb, pc, pt);
      idle_on = (p % 4 != 3);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_frame(1'b0);
    end
    wait_drained();
    if (mismatches == 0 && deframed_q.size() == 0) begin
      $display("** escaped_frame_deframer_unit: PASSED **");
    end else begin
      $display("** escaped_frame_deframer_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("** escaped_frame_deframer_unit: FAILED **");
    $finish;
  end

endmodule
